// ===== hdl/adamu_pkg.sv =====
package adamu_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [23:0] LR_RST  = 24'd16777;
  localparam logic [23:0] B1_RST  = 24'd15099494;
  localparam logic [23:0] B2_RST  = 24'd16760438;
  localparam logic [23:0] EPS_RST = 24'd1;
  localparam logic [24:0] C_RST   = 25'd16777216;
  localparam logic [24:0] ONE_Q24 = 25'h1000000;

  typedef enum logic [2:0] {
    CFG_LR  = 3'd0,
    CFG_B1  = 3'd1,
    CFG_B2  = 3'd2,
    CFG_EPS = 3'd3,
    CFG_C1  = 3'd4,
    CFG_C2  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [23:0] lr;
    logic [23:0] b1;
    logic [23:0] b2;
    logic [23:0] eps;
    logic [24:0] c1;
    logic [24:0] c2;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] g_out;
    logic signed [31:0] m;
    logic [30:0]        v;
    logic               active;
    logic               last;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t data;
  } q_wr_t;

  typedef struct packed {
    logic  empty;
    item_t data;
  } q_rd_t;

endpackage

// ===== hdl/adamu_front.sv =====
module adamu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  adamu_pkg::cfg_t     cfg_i,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_weight_in,
  input  logic signed [31:0]  in_grad_in,
  input  logic signed [31:0]  in_momentum_in,
  input  logic [30:0]         in_velocity_in,
  input  logic                in_row_active,
  input  logic                in_last_element,
  input  logic                q_full,
  output adamu_pkg::q_wr_t    q_wr
);
  import adamu_pkg::*;

  logic [3:0]         fv_r;
  logic               fen;
  item_t              fitm_r [3];
  item_t              qitm_r;

  logic [24:0]        omb1;
  logic [24:0]        omb2;
  logic signed [56:0] p1_c;
  logic signed [56:0] p2_c;
  logic [31:0]        gmag_c;
  logic [63:0]        gsqf_c;
  logic signed [56:0] p1_r;
  logic signed [56:0] p2_r;
  logic [63:0]        gsqf_r;

  logic signed [57:0] msum_c;
  logic signed [33:0] mr_c;
  logic signed [31:0] msat_c;
  logic [63:0]        gsum_c;
  logic signed [31:0] mnew2_r;
  logic [38:0]        gsq2_r;

  logic [54:0]        vp1_c;
  logic [63:0]        vp2_c;
  logic signed [31:0] mnew3_r;
  logic [54:0]        vp1_r;
  logic [63:0]        vp2_r;

  logic [64:0]        vacc_c;
  logic [40:0]        vn_c;
  logic [30:0]        vsat_c;
  item_t              qitm_nxt;

  assign fen      = !fv_r[3] || !q_full;
  assign in_ready = fen;
  assign q_wr.push = fv_r[3] && !q_full;
  assign q_wr.data = qitm_r;

  // stage 1: products
  assign omb1   = ONE_Q24 - {1'b0, cfg_i.b1};
  assign p1_c   = $signed({1'b0, cfg_i.b1}) * in_momentum_in;
  assign p2_c   = $signed({1'b0, omb1}) * in_grad_in;
  assign gmag_c = in_grad_in[31] ? 32'(-in_grad_in) : 32'(in_grad_in);
  assign gsqf_c = gmag_c * gmag_c;

  // stage 2: first moment rounding, square rounding
  assign msum_c = 58'(p1_r) + 58'(p2_r) + 58'sh800000;
  assign mr_c   = msum_c[57:24];
  always_comb begin
    if (mr_c[33:31] == 3'b000 || mr_c[33:31] == 3'b111) begin
      msat_c = mr_c[31:0];
    end else if (mr_c[33]) begin
      msat_c = 32'sh80000000;
    end else begin
      msat_c = 32'sh7FFFFFFF;
    end
  end
  assign gsum_c = gsqf_r + 64'h800000;

  // stage 3: second moment products
  assign omb2  = ONE_Q24 - {1'b0, cfg_i.b2};
  assign vp1_c = cfg_i.b2 * fitm_r[1].v;
  assign vp2_c = omb2 * gsq2_r;

  // stage 4: second moment rounding and pass-through select
  assign vacc_c = 65'(vp1_r) + 65'(vp2_r) + 65'h800000;
  assign vn_c   = vacc_c[64:24];
  assign vsat_c = (|vn_c[40:31]) ? 31'h7FFFFFFF : vn_c[30:0];

  always_comb begin
    qitm_nxt = fitm_r[2];
    if (fitm_r[2].active) begin
      qitm_nxt.g_out = '0;
      qitm_nxt.m     = mnew3_r;
      qitm_nxt.v     = vsat_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (fen) begin
      fv_r <= {fv_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      fitm_r[0].w      <= in_weight_in;
      fitm_r[0].g_out  <= in_grad_in;
      fitm_r[0].m      <= in_momentum_in;
      fitm_r[0].v      <= in_velocity_in;
      fitm_r[0].active <= in_row_active;
      fitm_r[0].last   <= in_last_element;
      p1_r             <= p1_c;
      p2_r             <= p2_c;
      gsqf_r           <= gsqf_c;
      fitm_r[1]        <= fitm_r[0];
      mnew2_r          <= msat_c;
      gsq2_r           <= gsum_c[62:24];
      fitm_r[2]        <= fitm_r[1];
      mnew3_r          <= mnew2_r;
      vp1_r            <= vp1_c;
      vp2_r            <= vp2_c;
      qitm_r           <= qitm_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> fv_r[0])
    else $error("accepted item did not enter the front pipeline");

  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r[3] && q_full |=> fv_r[3] && $stable(qitm_r))
    else $error("front item lost while queue full");
`endif

endmodule

// ===== hdl/adamu_queue.sv =====
module adamu_queue #(
  parameter int DEPTH = adamu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  adamu_pkg::q_wr_t  q_wr,
  output logic              q_full,
  input  logic              q_pop,
  output adamu_pkg::q_rd_t  q_rd
);
  import adamu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign q_full     = (cnt_r == CW'(DEPTH));
  assign q_rd.empty = (cnt_r == '0);
  assign q_rd.data  = mem_r[rp_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && !q_rd.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= q_wr.data;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> cnt_r != '0)
    else $error("queue empty after push");
`endif

endmodule

// ===== hdl/adamu_back.sv =====
module adamu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  adamu_pkg::cfg_t    cfg_i,
  input  adamu_pkg::q_rd_t   q_rd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_weight_out,
  output logic signed [31:0] out_grad_out,
  output logic signed [31:0] out_momentum_out,
  output logic [30:0]        out_velocity_out,
  output logic               out_sweep_done
);
  import adamu_pkg::*;

  localparam int MDIV_N = 32;
  localparam int SQ_N   = 28;
  localparam int SDIV_N = 33;
  localparam int S_MSAT = MDIV_N + 1;
  localparam int S_MUL  = S_MSAT + SQ_N + 1;
  localparam int S_OUT  = S_MUL + 1 + SDIV_N + 1;

  logic        en;
  logic [S_OUT:0] vld_r;
  item_t       itm_r [S_OUT];

  logic [24:0] c1e;
  logic [24:0] c2e;

  // moment bias-correction dividers
  logic [24:0] mrem_r [MDIV_N+1];
  logic [31:0] mlow_r [MDIV_N+1];
  logic        movf_r [MDIV_N+1];
  logic [24:0] vrem_r [MDIV_N+1];
  logic [31:0] vlow_r [MDIV_N+1];
  logic        vovf_r [MDIV_N+1];
  logic [31:0] mmag_c;

  // square root
  logic [55:0] sx_r    [SQ_N+1];
  logic [29:0] srem_r  [SQ_N+1];
  logic [27:0] sroot_r [SQ_N+1];
  logic [31:0] amag_r  [SQ_N+1];
  logic [31:0] mq_c;
  logic [31:0] amag_c;
  logic [30:0] vhat_c;

  // step numerator and denominator
  logic [55:0] num_r;
  logic [28:0] den_r;
  logic [28:0] dsum_c;

  // step divider
  logic [28:0] drem_r [SDIV_N+1];
  logic [32:0] dlow_r [SDIV_N+1];
  logic [28:0] dden_r [SDIV_N+1];
  logic        dovf_r [SDIV_N+1];

  logic [32:0]        qm_c;
  logic signed [34:0] step_c;
  logic signed [35:0] wsum_c;
  logic signed [31:0] wsat_c;
  item_t              last_itm;

  assign en        = !vld_r[S_OUT] || out_ready;
  assign q_pop     = en && !q_rd.empty;
  assign out_valid = vld_r[S_OUT];

  assign c1e = (cfg_i.c1 == '0) ? 25'd1 : cfg_i.c1;
  assign c2e = (cfg_i.c2 == '0) ? 25'd1 : cfg_i.c2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[S_OUT-1:0], !q_rd.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itm_r[0] <= q_rd.data;
      for (int k = 1; k < S_OUT; k++) begin
        itm_r[k] <= itm_r[k-1];
      end
    end
  end

  // divider set-up
  assign mmag_c = q_rd.data.m[31] ? 32'(-q_rd.data.m) : 32'(q_rd.data.m);

  always_ff @(posedge clk) begin
    if (en) begin
      movf_r[0] <= ({1'b0, mmag_c} >= {c1e, 8'b0});
      mrem_r[0] <= 25'(mmag_c[31:8]);
      mlow_r[0] <= {mmag_c[7:0], 24'b0};
      vovf_r[0] <= (33'(q_rd.data.v) >= {c2e, 8'b0});
      vrem_r[0] <= 25'(q_rd.data.v[30:8]);
      vlow_r[0] <= {q_rd.data.v[7:0], 24'b0};
    end
  end

  for (genvar k = 1; k <= MDIV_N; k++) begin : g_mdiv
    logic [25:0] mrs;
    logic [25:0] vrs;
    logic        mge;
    logic        vge;
    assign mrs = {mrem_r[k-1], mlow_r[k-1][31]};
    assign vrs = {vrem_r[k-1], vlow_r[k-1][31]};
    assign mge = (mrs >= {1'b0, c1e});
    assign vge = (vrs >= {1'b0, c2e});
    always_ff @(posedge clk) begin
      if (en) begin
        mrem_r[k] <= mge ? 25'(mrs - {1'b0, c1e}) : mrs[24:0];
        mlow_r[k] <= {mlow_r[k-1][30:0], mge};
        movf_r[k] <= movf_r[k-1];
        vrem_r[k] <= vge ? 25'(vrs - {1'b0, c2e}) : vrs[24:0];
        vlow_r[k] <= {vlow_r[k-1][30:0], vge};
        vovf_r[k] <= vovf_r[k-1];
      end
    end
  end

  // corrected moments, saturated
  assign mq_c = mlow_r[MDIV_N];
  always_comb begin
    if (itm_r[MDIV_N].m[31]) begin
      amag_c = (movf_r[MDIV_N] || mq_c > 32'h80000000) ? 32'h80000000 : mq_c;
    end else begin
      amag_c = (movf_r[MDIV_N] || mq_c[31]) ? 32'h7FFFFFFF : mq_c;
    end
  end
  assign vhat_c = (vovf_r[MDIV_N] || vlow_r[MDIV_N][31]) ? 31'h7FFFFFFF
                                                         : vlow_r[MDIV_N][30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r[0]    <= {1'b0, vhat_c, 24'b0};
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      amag_r[0]  <= amag_c;
    end
  end

  for (genvar j = 1; j <= SQ_N; j++) begin : g_sqrt
    logic [31:0] srs;
    logic [31:0] trial;
    logic        sge;
    assign srs   = {srem_r[j-1], sx_r[j-1][55:54]};
    assign trial = {2'b0, sroot_r[j-1], 2'b01};
    assign sge   = (srs >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[j]  <= sge ? 30'(srs - trial) : srs[29:0];
        sroot_r[j] <= {sroot_r[j-1][26:0], sge};
        sx_r[j]    <= {sx_r[j-1][53:0], 2'b00};
        amag_r[j]  <= amag_r[j-1];
      end
    end
  end

  assign dsum_c = 29'(sroot_r[SQ_N]) + 29'(cfg_i.eps);

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= cfg_i.lr * amag_r[SQ_N];
      den_r <= (dsum_c == '0) ? 29'd1 : dsum_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dovf_r[0] <= (29'(num_r[55:33]) >= den_r);
      drem_r[0] <= 29'(num_r[55:33]);
      dlow_r[0] <= num_r[32:0];
      dden_r[0] <= den_r;
    end
  end

  for (genvar j = 1; j <= SDIV_N; j++) begin : g_sdiv
    logic [29:0] drs;
    logic        dge;
    assign drs = {drem_r[j-1], dlow_r[j-1][32]};
    assign dge = (drs >= {1'b0, dden_r[j-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[j] <= dge ? 29'(drs - {1'b0, dden_r[j-1]}) : drs[28:0];
        dlow_r[j] <= {dlow_r[j-1][31:0], dge};
        dden_r[j] <= dden_r[j-1];
        dovf_r[j] <= dovf_r[j-1];
      end
    end
  end

  // weight update and result register
  assign last_itm = itm_r[S_OUT-1];
  assign qm_c     = dovf_r[SDIV_N] ? '1 : dlow_r[SDIV_N];
  assign step_c   = last_itm.m[31] ? -$signed({2'b0, qm_c}) : $signed({2'b0, qm_c});
  assign wsum_c   = 36'(last_itm.w) + 36'(step_c);
  always_comb begin
    if (wsum_c[35:31] == 5'b00000 || wsum_c[35:31] == 5'b11111) begin
      wsat_c = wsum_c[31:0];
    end else if (wsum_c[35]) begin
      wsat_c = 32'sh80000000;
    end else begin
      wsat_c = 32'sh7FFFFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_weight_out   <= last_itm.active ? wsat_c : last_itm.w;
      out_grad_out     <= last_itm.g_out;
      out_momentum_out <= last_itm.m;
      out_velocity_out <= last_itm.v;
      out_sweep_done   <= last_itm.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> vld_r[0])
    else $error("popped item did not enter the back pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("back pipeline moved during stall");
`endif

endmodule

// ===== hdl/adam_parameter_update_top.sv =====
// throughput: one item per cycle when out_ready does not stall the pipelines,
// set by the fully pipelined dividers and square root
// front: 4 stages of moment arithmetic, then a small queue, then a 98-stage back pipeline
// reset (synchronous, active low): empties the pipelines and queue, config to defaults
module adam_parameter_update_top #(
  parameter int QUEUE_DEPTH = adamu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_weight_in,
  input  logic signed [31:0] in_grad_in,
  input  logic signed [31:0] in_momentum_in,
  input  logic [30:0]        in_velocity_in,
  input  logic               in_row_active,
  input  logic               in_last_element,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_weight_out,
  output logic signed [31:0] out_grad_out,
  output logic signed [31:0] out_momentum_out,
  output logic [30:0]        out_velocity_out,
  output logic               out_sweep_done
);
  import adamu_pkg::*;

  cfg_t    cfg_r;
  q_wr_t   q_wr;
  q_rd_t   q_rd;
  logic    q_full;
  logic    q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lr  <= LR_RST;
      cfg_r.b1  <= B1_RST;
      cfg_r.b2  <= B2_RST;
      cfg_r.eps <= EPS_RST;
      cfg_r.c1  <= C_RST;
      cfg_r.c2  <= C_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LR:  cfg_r.lr  <= cfg_data[23:0];
        CFG_B1:  cfg_r.b1  <= cfg_data[23:0];
        CFG_B2:  cfg_r.b2  <= cfg_data[23:0];
        CFG_EPS: cfg_r.eps <= cfg_data[23:0];
        CFG_C1:  cfg_r.c1  <= cfg_data;
        CFG_C2:  cfg_r.c2  <= cfg_data;
        default: ;
      endcase
    end
  end

  adamu_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_i           (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_weight_in    (in_weight_in),
    .in_grad_in      (in_grad_in),
    .in_momentum_in  (in_momentum_in),
    .in_velocity_in  (in_velocity_in),
    .in_row_active   (in_row_active),
    .in_last_element (in_last_element),
    .q_full          (q_full),
    .q_wr            (q_wr)
  );

  adamu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  adamu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_i            (cfg_r),
    .q_rd             (q_rd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_weight_out   (out_weight_out),
    .out_grad_out     (out_grad_out),
    .out_momentum_out (out_momentum_out),
    .out_velocity_out (out_velocity_out),
    .out_sweep_done   (out_sweep_done)
  );

endmodule
